### hdl/rsfhd_pkg.sv
package rsfhd_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned RADIUS_W = 31;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned INF_W = 16;
   localparam int unsigned DIST_W = 33;
   localparam int unsigned SQ_W = 66;
   localparam int unsigned SUM_W = 40;
   localparam logic [INF_W-1:0] ONE_Q15 = 16'd32768;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CSR_GEN_COUNT = 2'd0,
      CSR_CELL_X = 2'd1,
      CSR_CELL_Z = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_VERTEX = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic start_vertex;
      logic load_entry;
      logic start_entry;
      logic clear_sum;
   } dp_cmd_type;

   typedef struct packed {
      logic entry_done;
   } dp_status_type;

   function automatic logic [INF_W-1:0] sine_entry(input logic [12:0] idx, input int depth);
      logic [63:0] a;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [64:0] s;
      logic signed [64:0] r;
      a = (64'(idx) * HALF_PI_Q30) / 64'(depth);
      x2 = (a * a) >> 30;
      term = a;
      s = $signed({1'b0, a});
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            s = s - $signed({1'b0, term});
         end else begin
            s = s + $signed({1'b0, term});
         end
      end
      if (s < 0) begin
         s = '0;
      end
      r = (s + 65'sd16384) >>> 15;
      if (r > 65'sd32768) begin
         r = 65'sd32768;
      end
      return r[INF_W-1:0];
   endfunction

endpackage

### hdl/rsfhd_ctrl.sv
module rsfhd_ctrl
   import rsfhd_pkg::*;
#(
   parameter int MAX_DEFORMERS = 64
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic req_type,
   input logic [COUNT_W-1:0] gen_count,
   output logic rsp_valid,
   input logic rsp_ready,
   output dp_cmd_type cmd,
   input dp_status_type status
);

   localparam int CNT_W = $clog2(MAX_DEFORMERS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] limit;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_DONE);
   assign limit = (32'(gen_count) > 32'(MAX_DEFORMERS)) ? CNT_W'(MAX_DEFORMERS)
                                                        : CNT_W'(gen_count);

   always_comb begin
      state_in = state_ff;
      left_in = left_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  cmd.load_entry = 1'b1;
               end else begin
                  cmd.start_vertex = 1'b1;
                  cmd.clear_sum = 1'b1;
                  left_in = limit;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cmd.start_entry = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.entry_done) begin
               left_in = left_ff - 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff <= '0;
      end else begin
         state_ff <= state_in;
         left_ff <= left_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (left_ff != '0))
      else $error("Entry in flight with no entries left.");
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_entry |=> (state_ff == ST_WAIT))
      else $error("Entry start did not enter the wait state.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("Result dropped before transfer.");

endmodule

### hdl/rsfhd_datapath.sv
module rsfhd_datapath
   import rsfhd_pkg::*;
#(
   parameter int MAX_DEFORMERS = 64,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input logic clock,
   input logic reset,
   input dp_cmd_type cmd,
   output dp_status_type status,
   input logic [5:0] gen_index,
   input logic signed [COORD_W-1:0] gen_x,
   input logic signed [COORD_W-1:0] gen_z,
   input logic [RADIUS_W-1:0] gen_radius,
   input logic signed [COORD_W-1:0] gen_height,
   input logic gen_lower,
   input logic signed [COORD_W-1:0] vert_x,
   input logic signed [COORD_W-1:0] vert_z,
   input logic signed [COORD_W-1:0] cell_x,
   input logic signed [COORD_W-1:0] cell_z,
   output logic signed [COORD_W-1:0] vert_height,
   output logic height_clipped
);

   localparam int IDX_W = (MAX_DEFORMERS > 1) ? $clog2(MAX_DEFORMERS) : 1;
   localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_READ,
      PH_DIFF,
      PH_SQX,
      PH_SQZ,
      PH_ROOT,
      PH_CHECK,
      PH_DIV,
      PH_SINE,
      PH_MUL,
      PH_ACC
   } phase_type;

   logic [COORD_W-1:0] mem_x [MAX_DEFORMERS];
   logic [COORD_W-1:0] mem_z [MAX_DEFORMERS];
   logic [RADIUS_W-1:0] mem_r [MAX_DEFORMERS];
   logic [COORD_W-1:0] mem_h [MAX_DEFORMERS];
   logic mem_l [MAX_DEFORMERS];
   logic [INF_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

   phase_type phase_ff;
   logic [IDX_W-1:0] entry_ff;
   logic signed [COORD_W:0] wx_ff, wz_ff;
   logic signed [COORD_W-1:0] ex_ff, ez_ff, eh_ff;
   logic [RADIUS_W-1:0] er_ff;
   logic el_ff;
   logic [DIST_W-1:0] ax_ff, az_ff;
   logic far_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [SQ_W-1:0] rem_ff;
   logic [DIST_W:0] root_ff;
   logic [6:0] step_ff;
   logic [INF_W-1:0] inf_ff;
   logic [DIST_W+DEPTH_LOG:0] num_ff;
   logic [SIDX_W-1:0] quo_ff;
   logic [RADIUS_W+1:0] drem_ff;
   logic signed [48:0] prod_ff;
   logic signed [SUM_W-1:0] sum_ff;

   logic signed [COORD_W+1:0] dx, dz;
   logic [RADIUS_W+1:0] dshift;
   logic signed [48:0] contrib;
   logic signed [SUM_W-1:0] sum_in;

   initial begin
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         sine_rom[i] = sine_entry(13'(i), SINE_TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_entry && (32'(gen_index) < 32'(MAX_DEFORMERS))) begin
         mem_x[IDX_W'(gen_index)] <= gen_x;
         mem_z[IDX_W'(gen_index)] <= gen_z;
         mem_r[IDX_W'(gen_index)] <= gen_radius;
         mem_h[IDX_W'(gen_index)] <= gen_height;
         mem_l[IDX_W'(gen_index)] <= gen_lower;
      end
      if (phase_ff == PH_READ) begin
         ex_ff <= mem_x[entry_ff];
         ez_ff <= mem_z[entry_ff];
         er_ff <= mem_r[entry_ff];
         eh_ff <= mem_h[entry_ff];
         el_ff <= mem_l[entry_ff];
      end
   end

   assign dx = 34'(ex_ff) - 34'(wx_ff);
   assign dz = 34'(ez_ff) - 34'(wz_ff);
   assign dshift = {drem_ff[RADIUS_W:0], num_ff[DIST_W+DEPTH_LOG]};
   assign contrib = prod_ff / 49'sd32768;
   assign sum_in = el_ff ? sum_ff - SUM_W'(contrib) : sum_ff + SUM_W'(contrib);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         entry_ff <= '0;
         sum_ff <= '0;
         status <= '0;
      end else begin
         status.entry_done <= (phase_ff == PH_ACC);
         if (cmd.start_vertex) begin
            wx_ff <= 33'(vert_x) + 33'(cell_x);
            wz_ff <= 33'(vert_z) + 33'(cell_z);
            entry_ff <= '0;
         end
         if (cmd.clear_sum) begin
            sum_ff <= '0;
         end
         case (phase_ff)
            PH_IDLE: begin
               if (cmd.start_entry) begin
                  phase_ff <= PH_READ;
               end
            end
            PH_READ: phase_ff <= PH_DIFF;
            PH_DIFF: begin
               ax_ff <= dx[COORD_W+1] ? DIST_W'(-dx) : DIST_W'(dx);
               az_ff <= dz[COORD_W+1] ? DIST_W'(-dz) : DIST_W'(dz);
               far_ff <= ((dx[COORD_W+1] ? -dx : dx) > 34'sd2147483648) ||
                         ((dz[COORD_W+1] ? -dz : dz) > 34'sd2147483648);
               phase_ff <= PH_SQX;
            end
            PH_SQX: begin
               sq_ff <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
               phase_ff <= PH_SQZ;
            end
            PH_SQZ: begin
               rem_ff <= sq_ff + SQ_W'(az_ff) * SQ_W'(az_ff);
               root_ff <= '0;
               step_ff <= 7'd33;
               phase_ff <= PH_ROOT;
            end
            PH_ROOT: begin
               if (step_ff == '0) begin
                  phase_ff <= PH_CHECK;
               end else begin
                  step_ff <= step_ff - 1'b1;
                  if (rem_ff >= ((SQ_W'(root_ff) << 2) + 66'd1) << (2 * (step_ff - 1))) begin
                     rem_ff <= rem_ff - (((SQ_W'(root_ff) << 2) + 66'd1) << (2 * (step_ff - 1)));
                     root_ff <= (root_ff << 1) | 34'd1;
                  end else begin
                     root_ff <= root_ff << 1;
                  end
               end
            end
            PH_CHECK: begin
               if (far_ff) begin
                  inf_ff <= '0;
                  phase_ff <= PH_MUL;
               end else if (er_ff == '0) begin
                  inf_ff <= (root_ff == '0) ? ONE_Q15 : '0;
                  phase_ff <= PH_MUL;
               end else if (root_ff > 34'(er_ff)) begin
                  inf_ff <= '0;
                  phase_ff <= PH_MUL;
               end else begin
                  num_ff <= (DIST_W+DEPTH_LOG+1)'(34'(er_ff) - root_ff) *
                            (DIST_W+DEPTH_LOG+1)'(SINE_TABLE_DEPTH);
                  drem_ff <= '0;
                  quo_ff <= '0;
                  step_ff <= 7'(DIST_W + DEPTH_LOG + 1);
                  phase_ff <= PH_DIV;
               end
            end
            PH_DIV: begin
               if (step_ff == '0) begin
                  phase_ff <= PH_SINE;
               end else begin
                  step_ff <= step_ff - 1'b1;
                  num_ff <= num_ff << 1;
                  if (dshift >= (RADIUS_W+2)'(er_ff)) begin
                     drem_ff <= dshift - (RADIUS_W+2)'(er_ff);
                     quo_ff <= (quo_ff << 1) | SIDX_W'(1);
                  end else begin
                     drem_ff <= dshift;
                     quo_ff <= quo_ff << 1;
                  end
               end
            end
            PH_SINE: begin
               inf_ff <= sine_rom[quo_ff];
               phase_ff <= PH_MUL;
            end
            PH_MUL: begin
               prod_ff <= 49'(eh_ff) * $signed({33'd0, inf_ff});
               phase_ff <= PH_ACC;
            end
            PH_ACC: begin
               sum_ff <= sum_in;
               entry_ff <= entry_ff + 1'b1;
               phase_ff <= PH_IDLE;
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   always_comb begin
      height_clipped = 1'b0;
      vert_height = sum_ff[COORD_W-1:0];
      if (sum_ff > SUM_W'(64'sd2147483647)) begin
         vert_height = 32'h7FFF_FFFF;
         height_clipped = 1'b1;
      end else if (sum_ff < -SUM_W'(64'sd2147483648)) begin
         vert_height = 32'h8000_0000;
         height_clipped = 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      status.entry_done |-> (phase_ff == PH_IDLE))
      else $error("Entry done outside idle phase.");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHECK && far_ff) |=> (phase_ff == PH_MUL && inf_ff == '0))
      else $error("Far entry gave influence.");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SINE) |=> (inf_ff <= ONE_Q15))
      else $error("Influence above one.");

endmodule

### hdl/radial_sine_falloff_height_deform.sv
// A vertex result sums the first n table entries, n being gen_count capped at the table
// size, one entry after another, each with the 33-step root and the 44-step divide; an
// entry that is far, out of range or of zero radius skips the divide and the sine lookup.
// Throughput: one item at a time; the next item is accepted once the result transfers.
// Reset is synchronous, active high; it clears the CSRs, controller, phase and sum.
// The deformer table has no reset and must be loaded before use.
module radial_sine_falloff_height_deform
   import rsfhd_pkg::*;
#(
   parameter int MAX_DEFORMERS = 64,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [31:0] csr_data,
   input logic req_valid,
   output logic req_ready,
   input logic req_type,
   input logic [5:0] req_gen_index,
   input logic signed [31:0] req_gen_x,
   input logic signed [31:0] req_gen_z,
   input logic [30:0] req_gen_radius,
   input logic signed [31:0] req_gen_height,
   input logic req_gen_lower,
   input logic signed [31:0] req_vert_x,
   input logic signed [31:0] req_vert_z,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic signed [31:0] rsp_vert_height,
   output logic rsp_height_clipped
);

   logic [COUNT_W-1:0] gen_count_ff;
   logic signed [COORD_W-1:0] cell_x_ff, cell_z_ff;
   dp_cmd_type cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_count_ff <= '0;
         cell_x_ff <= '0;
         cell_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GEN_COUNT: gen_count_ff <= csr_data[COUNT_W-1:0];
            CSR_CELL_X: cell_x_ff <= csr_data;
            CSR_CELL_Z: cell_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rsfhd_ctrl #(.MAX_DEFORMERS(MAX_DEFORMERS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .gen_count(gen_count_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .status(status)
   );

   rsfhd_datapath #(.MAX_DEFORMERS(MAX_DEFORMERS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH))
   u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .gen_index(req_gen_index), .gen_x(req_gen_x), .gen_z(req_gen_z),
      .gen_radius(req_gen_radius), .gen_height(req_gen_height),
      .gen_lower(req_gen_lower), .vert_x(req_vert_x), .vert_z(req_vert_z),
      .cell_x(cell_x_ff), .cell_z(cell_z_ff),
      .vert_height(rsp_vert_height), .height_clipped(rsp_height_clipped)
   );

endmodule

### bench/radial_sine_falloff_height_deform_tb.sv
`timescale 1ns / 1ps

module radial_sine_falloff_height_deform_tb
   import rsfhd_pkg::*;
();

   localparam int TABLE_SLOTS = 64;
   localparam int LUT_DEPTH = 1024;
   localparam int IDLE_LIMIT = 100000;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam longint FAR_DIST = 64'sd2147483648;

   typedef struct {
      req_kind_type kind;
      logic [5:0] slot;
      logic signed [31:0] gx;
      logic signed [31:0] gz;
      logic [30:0] radius;
      logic signed [31:0] amount;
      logic lower;
      logic signed [31:0] vx;
      logic signed [31:0] vz;
   } deform_req_type;

   typedef struct {
      logic signed [31:0] height;
      logic clipped;
   } height_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [5:0] req_gen_index = '0;
   logic signed [31:0] req_gen_x = '0;
   logic signed [31:0] req_gen_z = '0;
   logic [30:0] req_gen_radius = '0;
   logic signed [31:0] req_gen_height = '0;
   logic req_gen_lower = 1'b0;
   logic signed [31:0] req_vert_x = '0;
   logic signed [31:0] req_vert_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_vert_height;
   logic rsp_height_clipped;

   radial_sine_falloff_height_deform u_top (.*);

   longint sine_lut [0:LUT_DEPTH];
   longint deform_x [TABLE_SLOTS];
   longint deform_z [TABLE_SLOTS];
   longint deform_r [TABLE_SLOTS];
   longint deform_amount [TABLE_SLOTS];
   logic deform_lower [TABLE_SLOTS];
   int applied_count = 0;
   longint offset_x = 0;
   longint offset_z = 0;

   height_result_type pending_heights[$];
   int error_count = 0;
   int burst_left = 0;
   int long_hold = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic build_sine_lut();
      longint unsigned a, x2, term;
      longint s, r;
      for (int i = 0; i <= LUT_DEPTH; i++) begin
         a = (64'(i) * HALF_PI_Q30) / 64'(LUT_DEPTH);
         x2 = (a * a) >> 30;
         term = a;
         s = longint'(a);
         for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
         end
         if (s < 0) s = 0;
         r = (s + 16384) / 32768;
         sine_lut[i] = (r > 32768) ? 32768 : r;
      end
   endtask

   function automatic longint falloff_weight(longint dx, longint dz, longint r);
      longint unsigned ax, az, d;
      ax = (dx < 0) ? -dx : dx;
      az = (dz < 0) ? -dz : dz;
      if (ax > FAR_DIST || az > FAR_DIST) return 0;
      d = root64(ax * ax + az * az);
      if (r == 0) return (d == 0) ? 32768 : 0;
      if (d > r) return 0;
      return sine_lut[((r - d) * LUT_DEPTH) / r];
   endfunction

   function automatic height_result_type predict_height(longint vx, longint vz);
      height_result_type res;
      longint wx, wz, c;
      longint total = 0;
      int n;
      wx = vx + offset_x;
      wz = vz + offset_z;
      n = (applied_count > TABLE_SLOTS) ? TABLE_SLOTS : applied_count;
      for (int i = 0; i < n; i++) begin
         c = (deform_amount[i] *
              falloff_weight(deform_x[i] - wx, deform_z[i] - wz, deform_r[i])) / 32768;
         total = deform_lower[i] ? total - c : total + c;
      end
      res.clipped = 1'b1;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      else if (total < -64'sd2147483648) total = -64'sd2147483648;
      else res.clipped = 1'b0;
      res.height = total[31:0];
      return res;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic int active_slots();
      return (applied_count > TABLE_SLOTS) ? TABLE_SLOTS : applied_count;
   endfunction

   task automatic report_mismatch(string what, longint expected, longint got);
      $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, expected, got);
      error_count++;
   endtask

   task automatic send_item(deform_req_type it);
      int gap;
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_gen_index <= it.slot;
      req_gen_x <= it.gx;
      req_gen_z <= it.gz;
      req_gen_radius <= it.radius;
      req_gen_height <= it.amount;
      req_gen_lower <= it.lower;
      req_vert_x <= it.vx;
      req_vert_z <= it.vz;
      do @(posedge clock); while (!req_ready);
      if (it.kind == REQ_LOAD) begin
         deform_x[it.slot] = it.gx;
         deform_z[it.slot] = it.gz;
         deform_r[it.slot] = it.radius;
         deform_amount[it.slot] = it.amount;
         deform_lower[it.slot] = it.lower;
      end else begin
         pending_heights = {pending_heights, predict_height(it.vx, it.vz)};
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 8);
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GEN_COUNT: applied_count = value[6:0];
         CSR_CELL_X: offset_x = longint'($signed(value));
         CSR_CELL_Z: offset_z = longint'($signed(value));
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic deform_req_type load_req(int slot, longint x, longint z, longint r,
                                               longint amount, logic lower);
      deform_req_type it;
      it.kind = REQ_LOAD;
      it.slot = 6'(slot);
      it.gx = 32'(x);
      it.gz = 32'(z);
      it.radius = 31'(r);
      it.amount = 32'(amount);
      it.lower = lower;
      it.vx = $urandom;
      it.vz = $urandom;
      return it;
   endfunction

   function automatic deform_req_type vertex_req(longint x, longint z);
      deform_req_type it;
      it = load_req($urandom_range(0, 63), $signed($urandom), $signed($urandom),
                    $urandom & 32'h7FFFFFFF, $signed($urandom), $urandom_range(0, 1));
      it.kind = REQ_VERTEX;
      it.vx = 32'(x);
      it.vz = 32'(z);
      return it;
   endfunction

   function automatic deform_req_type random_load();
      int slot = $urandom_range(0, TABLE_SLOTS - 1);
      if ($urandom_range(0, 4) == 0)
         return load_req(slot, $signed($urandom), $signed($urandom), $urandom & 32'h7FFFFFFF,
                         $signed($urandom), $urandom_range(0, 1));
      return load_req(slot, longint'($urandom_range(0, 1 << 23)) - (1 << 22),
                      longint'($urandom_range(0, 1 << 23)) - (1 << 22),
                      ($urandom & 32'h7FFFFFFF) >> $urandom_range(0, 30),
                      longint'($signed($urandom)) >>> $urandom_range(0, 16),
                      $urandom_range(0, 1));
   endfunction

   function automatic deform_req_type random_vertex();
      int n = active_slots();
      int j;
      longint ox, oz;
      if (n == 0 || $urandom_range(0, 4) == 0)
         return vertex_req($signed($urandom), $signed($urandom));
      j = $urandom_range(0, n - 1);
      ox = 0;
      oz = 0;
      if ($urandom_range(0, 4) != 0) begin
         ox = $urandom_range(0, 32'(deform_r[j] / 2));
         oz = $urandom_range(0, 32'(deform_r[j] / 2));
         if ($urandom_range(0, 1)) ox = -ox;
         if ($urandom_range(0, 1)) oz = -oz;
      end
      return vertex_req(clamp32(deform_x[j] + ox - offset_x),
                        clamp32(deform_z[j] + oz - offset_z));
   endfunction

   always @(posedge clock) begin
      if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_ready <= 1'b0;
      end else if (($time / 2000) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(0, 9) < 6;
      end
   end

   always @(posedge clock) begin
      height_result_type exp_res;
      if (rsp_valid && rsp_ready) begin
         if (pending_heights.size() == 0) begin
            report_mismatch("unexpected result, height", 0, rsp_vert_height);
         end else begin
            exp_res = pending_heights.pop_front();
            if (rsp_vert_height !== exp_res.height)
               report_mismatch("vert_height", exp_res.height, rsp_vert_height);
            if (rsp_height_clipped !== exp_res.clipped)
               report_mismatch("height_clipped", exp_res.clipped, rsp_height_clipped);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_empty_count();
      write_csr(CSR_UNMAPPED, 32'hFFFFFFFF);
      send_item(vertex_req(0, 0));
      send_item(vertex_req(32'sh7FFFFFFF, 32'sh80000000));
      drain();
   endtask

   task automatic test_directed_extremes();
      for (int i = 0; i < 4; i++) send_item(load_req(i, 0, 0, 0, 32'sh7FFFFFFF, 1'b0));
      drain();
      write_csr(CSR_GEN_COUNT, 4);
      send_item(vertex_req(0, 0));
      send_item(vertex_req(1, 0));
      for (int i = 0; i < 4; i++) send_item(load_req(i, 0, 0, 0, 32'sh7FFFFFFF, 1'b1));
      send_item(vertex_req(0, 0));
      send_item(load_req(0, 0, 0, 32'h7FFFFFFF, -64'sd2147483648, 1'b1));
      send_item(load_req(1, -64'sd2147483648, 32'sh7FFFFFFF, 65536, 65536, 1'b0));
      send_item(load_req(2, 0, 0, 65536, -65536, 1'b0));
      send_item(load_req(3, 0, 0, 0, -64'sd2147483648, 1'b1));
      send_item(vertex_req(0, 0));
      send_item(vertex_req(65536, 0));
      send_item(vertex_req(65537, 0));
      send_item(vertex_req(32'sh80000000, 32'sh7FFFFFFF));
      drain();
      write_csr(CSR_CELL_X, 32'h7FFFFFFF);
      write_csr(CSR_CELL_Z, 32'h80000000);
      send_item(vertex_req(32'sh7FFFFFFF, 32'sh80000000));
      send_item(vertex_req(32'sh80000000, 32'sh7FFFFFFF));
      drain();
      write_csr(CSR_CELL_X, 0);
      write_csr(CSR_CELL_Z, 0);
   endtask

   task automatic test_fill_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         deform_req_type it = random_load();
         it.slot = 6'(i);
         send_item(it);
      end
      drain();
   endtask

   task automatic test_random_phases();
      int counts[8] = '{1, 3, 8, 64, 127, 2, 5, 0};
      int items;
      for (int p = 0; p < 8; p++) begin
         drain();
         write_csr(CSR_GEN_COUNT, counts[p]);
         case ($urandom_range(0, 3))
            0: begin
               write_csr(CSR_CELL_X, $urandom);
               write_csr(CSR_CELL_Z, $urandom);
            end
            1: begin
               write_csr(CSR_CELL_X, $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
               write_csr(CSR_CELL_Z, $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
            end
            default: begin
               write_csr(CSR_CELL_X, $urandom_range(0, 1 << 20));
               write_csr(CSR_CELL_Z, -$urandom_range(0, 1 << 20));
            end
         endcase
         items = (counts[p] >= TABLE_SLOTS) ? 5 : 8;
         for (int k = 0; k < items; k++)
            send_item($urandom_range(0, 3) == 0 ? random_load() : random_vertex());
      end
      drain();
   endtask

   task automatic test_output_stall();
      write_csr(CSR_GEN_COUNT, 2);
      long_hold = 400;
      burst_left = 10;
      for (int k = 0; k < 6; k++) send_item(random_vertex());
      drain();
   endtask

   initial begin
      build_sine_lut();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_count();
      test_directed_extremes();
      test_fill_table();
      test_random_phases();
      test_output_stall();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
hdl/rsfhd_pkg.sv
hdl/rsfhd_ctrl.sv
hdl/rsfhd_datapath.sv
hdl/radial_sine_falloff_height_deform.sv
bench/radial_sine_falloff_height_deform_tb.sv
